>>> hw/rtl/wls_pkg.sv
package wls_pkg;

  // Pixel store and waveform sizes
  localparam int PIX_DEPTH    = 16;
  localparam int PIX_AW       = $clog2(PIX_DEPTH);
  localparam int PTR_W        = PIX_AW + 1;
  localparam int TIME_BITS    = 12;
  localparam int COLOR_W      = 24;
  localparam int BITS_PER_PIX = 24;
  localparam int CNT_W        = $clog2(BITS_PER_PIX + 1);
  localparam int PCNT_W       = 5;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 12;

  typedef logic [1:0] func_t;

  localparam func_t FUNC_STORE = 2'd0;
  localparam func_t FUNC_START = 2'd1;
  localparam func_t FUNC_TICK  = 2'd2;

  localparam logic [CFG_AW-1:0] CFG_ONE_HIGH  = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_ONE_LOW   = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_ZERO_HIGH = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_ZERO_LOW  = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_PIX_COUNT = 3'd4;

  localparam logic [TIME_BITS-1:0] RST_ONE_HIGH  = TIME_BITS'(650);
  localparam logic [TIME_BITS-1:0] RST_ONE_LOW   = TIME_BITS'(600);
  localparam logic [TIME_BITS-1:0] RST_ZERO_HIGH = TIME_BITS'(500);
  localparam logic [TIME_BITS-1:0] RST_ZERO_LOW  = TIME_BITS'(850);
  localparam logic [PCNT_W-1:0]    RST_PIX_COUNT = PCNT_W'(16);

  typedef struct packed {
    logic [TIME_BITS-1:0] one_high;
    logic [TIME_BITS-1:0] one_low;
    logic [TIME_BITS-1:0] zero_high;
    logic [TIME_BITS-1:0] zero_low;
    logic [PCNT_W-1:0]    pixel_count;
  } cfg_t;

  typedef struct packed {
    logic               we;
    logic [PIX_AW-1:0]  waddr;
    logic [COLOR_W-1:0] wdata;
    logic [PIX_AW-1:0]  raddr;
  } store_ctl_t;

  // A phase length of zero runs as one tick
  function automatic logic [TIME_BITS-1:0] clamp_ticks(input logic [TIME_BITS-1:0] v);
    clamp_ticks = (v == '0) ? TIME_BITS'(1) : v;
  endfunction

  // Pixels per frame, held to 1 .. PIX_DEPTH
  function automatic logic [PTR_W-1:0] frame_len(input logic [PCNT_W-1:0] c);
    if (c == '0) begin
      frame_len = PTR_W'(1);
    end else if (PTR_W'(c) > PTR_W'(PIX_DEPTH)) begin
      frame_len = PTR_W'(PIX_DEPTH);
    end else begin
      frame_len = PTR_W'(c);
    end
  endfunction

endpackage

>>> hw/rtl/wls_in_if.sv
interface wls_in_if import wls_pkg::*; ();
  logic               valid;
  logic               ready;
  func_t              func;
  logic [PIX_AW-1:0]  pixel_index;
  logic [COLOR_W-1:0] color;

  modport source (output valid, output func, output pixel_index, output color, input ready);
  modport sink   (input valid, input func, input pixel_index, input color, output ready);
endinterface

>>> hw/rtl/wls_out_if.sv
interface wls_out_if import wls_pkg::*; ();
  logic valid;
  logic ready;
  logic pin_level;
  logic busy_res;
  logic frame_done;

  modport source (output valid, output pin_level, output busy_res, output frame_done,
                  input ready);
  modport sink   (input valid, input pin_level, input busy_res, input frame_done,
                  output ready);
endinterface

>>> hw/rtl/wls_pixel_store.sv
module wls_pixel_store import wls_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  store_ctl_t         ctl,
  output logic [COLOR_W-1:0] rd_data
);

  logic [COLOR_W-1:0] pix [PIX_DEPTH];

  // Clear all slots at reset, write one slot per store
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIX_DEPTH; i++) begin
        pix[i] <= '0;
      end
    end else if (ctl.we) begin
      pix[ctl.waddr] <= ctl.wdata;
    end
  end

  assign rd_data = pix[ctl.raddr];

endmodule

>>> hw/rtl/wls_engine.sv
module wls_engine import wls_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  func_t              func,
  input  logic [PIX_AW-1:0]  pixel_index,
  input  logic [COLOR_W-1:0] color,
  input  cfg_t               cfg,
  input  logic [COLOR_W-1:0] rd_data,
  output store_ctl_t         store_ctl,
  output logic               pin_level,
  output logic               busy_res,
  output logic               frame_done
);

  logic [COLOR_W-1:0]   shift_word, shift_word_next;
  logic [PIX_AW-1:0]    pixel_pointer, pixel_pointer_next;
  logic [CNT_W-1:0]     bits_left, bits_left_next;
  logic                 in_low_phase, in_low_phase_next;
  logic [TIME_BITS-1:0] ticks_left, ticks_left_next;
  logic                 sending, sending_next;
  logic                 line_level, line_level_next;

  logic [TIME_BITS-1:0] ticks_dec;
  logic [COLOR_W-1:0]   shifted;
  logic [CNT_W-1:0]     bits_dec;
  logic [PTR_W-1:0]     ptr_inc;
  logic                 is_start;

  assign ticks_dec = (ticks_left != '0) ? ticks_left - TIME_BITS'(1) : ticks_left;
  assign shifted   = {shift_word[COLOR_W-2:0], 1'b0};
  assign bits_dec  = (bits_left != '0) ? bits_left - CNT_W'(1) : bits_left;
  assign ptr_inc   = PTR_W'(pixel_pointer) + PTR_W'(1);
  assign is_start  = (func == FUNC_START) && !sending;

  // Pixel store: write on idle store, read slot 0 on start, else the next slot
  always_comb begin
    store_ctl.we    = step && (func == FUNC_STORE) && !sending;
    store_ctl.waddr = pixel_index;
    store_ctl.wdata = color;
    store_ctl.raddr = is_start ? '0 : ptr_inc[PIX_AW-1:0];
  end

  // Advance the waveform state for one item
  always_comb begin
    shift_word_next    = shift_word;
    pixel_pointer_next = pixel_pointer;
    bits_left_next     = bits_left;
    in_low_phase_next  = in_low_phase;
    ticks_left_next    = ticks_left;
    sending_next       = sending;
    line_level_next    = line_level;
    frame_done         = 1'b0;

    if (step && is_start) begin
      sending_next       = 1'b1;
      pixel_pointer_next = '0;
      shift_word_next    = rd_data;
      bits_left_next     = CNT_W'(BITS_PER_PIX);
      in_low_phase_next  = 1'b0;
      line_level_next    = 1'b1;
      ticks_left_next    = clamp_ticks(rd_data[COLOR_W-1] ? cfg.one_high : cfg.zero_high);
    end else if (step && (func == FUNC_TICK) && sending) begin
      ticks_left_next = ticks_dec;
      if (ticks_dec == '0) begin
        if (!in_low_phase) begin
          // High phase over: drop the line for the low phase
          in_low_phase_next = 1'b1;
          line_level_next   = 1'b0;
          ticks_left_next   = clamp_ticks(shift_word[COLOR_W-1] ? cfg.one_low
                                                                 : cfg.zero_low);
        end else if (bits_dec == '0) begin
          // Pixel over: end the frame or load the next pixel
          bits_left_next = bits_dec;
          if (ptr_inc >= frame_len(cfg.pixel_count)) begin
            shift_word_next    = shifted;
            pixel_pointer_next = ptr_inc[PIX_AW-1:0];
            sending_next       = 1'b0;
            in_low_phase_next  = 1'b0;
            line_level_next    = 1'b0;
            ticks_left_next    = '0;
            frame_done         = 1'b1;
          end else begin
            pixel_pointer_next = ptr_inc[PIX_AW-1:0];
            shift_word_next    = rd_data;
            bits_left_next     = CNT_W'(BITS_PER_PIX);
            in_low_phase_next  = 1'b0;
            line_level_next    = 1'b1;
            ticks_left_next    = clamp_ticks(rd_data[COLOR_W-1] ? cfg.one_high
                                                                : cfg.zero_high);
          end
        end else begin
          // Bit over: shift to the next bit and raise the line
          shift_word_next   = shifted;
          bits_left_next    = bits_dec;
          in_low_phase_next = 1'b0;
          line_level_next   = 1'b1;
          ticks_left_next   = clamp_ticks(shifted[COLOR_W-1] ? cfg.one_high : cfg.zero_high);
        end
      end
    end
  end

  // Hold the waveform state
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_word    <= '0;
      pixel_pointer <= '0;
      bits_left     <= '0;
      in_low_phase  <= 1'b0;
      ticks_left    <= '0;
      sending       <= 1'b0;
      line_level    <= 1'b0;
    end else begin
      shift_word    <= shift_word_next;
      pixel_pointer <= pixel_pointer_next;
      bits_left     <= bits_left_next;
      in_low_phase  <= in_low_phase_next;
      ticks_left    <= ticks_left_next;
      sending       <= sending_next;
      line_level    <= line_level_next;
    end
  end

  assign pin_level = line_level_next;
  assign busy_res  = sending_next;

endmodule

>>> hw/rtl/ws2812_led_serializer.sv
// One-wire LED chain serializer.
// Input channel req carries one item per handshake: func selects a pixel
// store (pixel_index, color), a frame start, or one time tick. Each tick
// moves the data line by one time step; every color bit goes out MSB first
// as a high phase and a low phase whose lengths in ticks come from the
// configuration registers (written through cfg_we / cfg_index / cfg_data).
// Output channel rsp returns one item per input item: pin_level, busy_res
// and frame_done, the last high only on the tick that ends the frame.
// An accepted item waits in the input register until the result register is
// free or being drained, and then moves into the result register for rsp.
// Throughput: one item per cycle while rsp does not stall.
// Reset (rst, synchronous) clears the pixel store, stops any frame, drives
// the line low and loads the default phase lengths and a 16 pixel frame.
// When rsp stalls the result is held, the input register fills, and
// req.ready drops once both stages are full; nothing is lost.
module ws2812_led_serializer import wls_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  wls_in_if.sink            req,
  wls_out_if.source         rsp,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  cfg_t               cfg;
  store_ctl_t         store_ctl;
  logic [COLOR_W-1:0] rd_data;

  logic               s1_valid;
  func_t              s1_func;
  logic [PIX_AW-1:0]  s1_index;
  logic [COLOR_W-1:0] s1_color;

  logic advance;
  logic step;
  logic eng_pin;
  logic eng_busy;
  logic eng_done;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.one_high    <= RST_ONE_HIGH;
      cfg.one_low     <= RST_ONE_LOW;
      cfg.zero_high   <= RST_ZERO_HIGH;
      cfg.zero_low    <= RST_ZERO_LOW;
      cfg.pixel_count <= RST_PIX_COUNT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ONE_HIGH:  cfg.one_high    <= cfg_data[TIME_BITS-1:0];
        CFG_ONE_LOW:   cfg.one_low     <= cfg_data[TIME_BITS-1:0];
        CFG_ZERO_HIGH: cfg.zero_high   <= cfg_data[TIME_BITS-1:0];
        CFG_ZERO_LOW:  cfg.zero_low    <= cfg_data[TIME_BITS-1:0];
        CFG_PIX_COUNT: cfg.pixel_count <= cfg_data[PCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Move an item on when the result register is free or being drained
  assign advance   = !rsp.valid || rsp.ready;
  assign step      = s1_valid && advance;
  assign req.ready = !s1_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_func  <= req.func;
      s1_index <= req.pixel_index;
      s1_color <= req.color;
    end
  end

  wls_pixel_store u_store (
    .clk     (clk),
    .rst     (rst),
    .ctl     (store_ctl),
    .rd_data (rd_data)
  );

  wls_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .func        (s1_func),
    .pixel_index (s1_index),
    .color       (s1_color),
    .cfg         (cfg),
    .rd_data     (rd_data),
    .store_ctl   (store_ctl),
    .pin_level   (eng_pin),
    .busy_res    (eng_busy),
    .frame_done  (eng_done)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (advance) begin
      rsp.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      rsp.pin_level  <= eng_pin;
      rsp.busy_res   <= eng_busy;
      rsp.frame_done <= eng_done;
    end
  end

endmodule

>>> sim/ws2812_led_serializer_tb.sv
module ws2812_led_serializer_tb;
  import wls_pkg::*;

  localparam func_t FUNC_UNUSED = 2'd3;
  localparam logic [CFG_AW-1:0] CFG_UNUSED = 3'd5;
  localparam int GAP_PCT      = 17;
  localparam int DRAIN_CYCLES = 8;
  localparam int WATCHDOG     = 2000;
  localparam int RANDOM_ITEMS = 250;

  typedef struct packed {
    logic pin_level;
    logic busy_res;
    logic frame_done;
  } line_status_t;

  // Tracks the serializer state and holds the line status due for each item
  class led_frame_scoreboard;
    logic [TIME_BITS-1:0] one_high, one_low, zero_high, zero_low;
    logic [PCNT_W-1:0]    pix_count;
    logic [COLOR_W-1:0]   pixels [PIX_DEPTH];
    logic [COLOR_W-1:0]   shift_word;
    logic [PTR_W-1:0]     pix_ptr;
    logic [CNT_W-1:0]     bits_left;
    logic [TIME_BITS-1:0] ticks_left;
    bit                   low_phase, sending, line;
    line_status_t         pending [$];
    int                   errors;

    function void reset_state();
      one_high   = RST_ONE_HIGH;
      one_low    = RST_ONE_LOW;
      zero_high  = RST_ZERO_HIGH;
      zero_low   = RST_ZERO_LOW;
      pix_count  = RST_PIX_COUNT;
      foreach (pixels[i]) pixels[i] = '0;
      shift_word = '0;
      pix_ptr    = '0;
      bits_left  = '0;
      ticks_left = '0;
      low_phase  = 1'b0;
      sending    = 1'b0;
      line       = 1'b0;
      pending.delete();
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
      case (idx)
        CFG_ONE_HIGH:  one_high  = data;
        CFG_ONE_LOW:   one_low   = data;
        CFG_ZERO_HIGH: zero_high = data;
        CFG_ZERO_LOW:  zero_low  = data;
        CFG_PIX_COUNT: pix_count = data[PCNT_W-1:0];
        default: ;
      endcase
    endfunction

    // Zero-length phases still last one tick
    function logic [TIME_BITS-1:0] phase_ticks(logic [TIME_BITS-1:0] v);
      return (v == '0) ? TIME_BITS'(1) : v;
    endfunction

    function logic [PTR_W-1:0] frame_pixels();
      if (pix_count == '0) return PTR_W'(1);
      if (pix_count > PCNT_W'(PIX_DEPTH)) return PTR_W'(PIX_DEPTH);
      return PTR_W'(pix_count);
    endfunction

    function void open_high();
      low_phase  = 1'b0;
      line       = 1'b1;
      ticks_left = phase_ticks(shift_word[COLOR_W-1] ? one_high : zero_high);
    endfunction

    function void note_item(func_t f, logic [PIX_AW-1:0] idx, logic [COLOR_W-1:0] c);
      line_status_t st;
      st.frame_done = 1'b0;
      case (f)
        FUNC_STORE: if (!sending) pixels[idx] = c;
        FUNC_START: begin
          if (!sending) begin
            sending    = 1'b1;
            pix_ptr    = '0;
            shift_word = pixels[0];
            bits_left  = CNT_W'(BITS_PER_PIX);
            open_high();
          end
        end
        FUNC_TICK: begin
          if (sending) begin
            if (ticks_left != '0) ticks_left--;
            if (ticks_left == '0) begin
              if (!low_phase) begin
                // high phase over: drop the line for the low phase
                low_phase  = 1'b1;
                line       = 1'b0;
                ticks_left = phase_ticks(shift_word[COLOR_W-1] ? one_low : zero_low);
              end else begin
                // low phase over: advance to next bit, next pixel or frame end
                shift_word = shift_word << 1;
                if (bits_left != '0) bits_left--;
                if (bits_left == '0) begin
                  pix_ptr++;
                  if (pix_ptr >= frame_pixels()) begin
                    sending       = 1'b0;
                    low_phase     = 1'b0;
                    line          = 1'b0;
                    ticks_left    = '0;
                    st.frame_done = 1'b1;
                  end else begin
                    shift_word = pixels[pix_ptr[PIX_AW-1:0]];
                    bits_left  = CNT_W'(BITS_PER_PIX);
                    open_high();
                  end
                end else begin
                  open_high();
                end
              end
            end
          end
        end
        default: ;
      endcase
      st.pin_level = line;
      st.busy_res  = sending;
      pending.push_back(st);
    endfunction

    function void check_result(logic pin, logic busy, logic done);
      line_status_t exp_st;
      if (pending.size() == 0) begin
        $error("unexpected item: pin_level %0b busy_res %0b frame_done %0b", pin, busy, done);
        errors++;
        return;
      end
      exp_st = pending.pop_front();
      if (pin !== exp_st.pin_level) begin
        $error("pin_level: expected %0b, actual %0b", exp_st.pin_level, pin);
        errors++;
      end
      if (busy !== exp_st.busy_res) begin
        $error("busy_res: expected %0b, actual %0b", exp_st.busy_res, busy);
        errors++;
      end
      if (done !== exp_st.frame_done) begin
        $error("frame_done: expected %0b, actual %0b", exp_st.frame_done, done);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;
  bit                no_gaps = 1'b0;
  int                items_sent = 0;
  int                quiet_cycles = 0;

  led_frame_scoreboard sb = new;

  wls_in_if  req_if ();
  wls_out_if rsp_if ();

  ws2812_led_serializer u_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_if),
    .rsp       (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Check each returned item and stall the result channel at random
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      sb.check_result(rsp_if.pin_level, rsp_if.busy_res, rsp_if.frame_done);
    end
    rsp_if.ready <= no_gaps || ($urandom_range(99) >= GAP_PCT);
  end

  // End the run when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG) begin
      $display("ws2812_led_serializer_tb: done, errors");
      $finish;
    end
  end

  function automatic logic [COLOR_W-1:0] rand_color();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return COLOR_W'($urandom);
    endcase
  endfunction

  // Offer one item, idling at random first; returns right after acceptance
  task automatic send_item(input func_t f, input logic [PIX_AW-1:0] idx,
                           input logic [COLOR_W-1:0] c);
    while (!no_gaps && $urandom_range(99) < GAP_PCT) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.func        <= f;
    req_if.pixel_index <= idx;
    req_if.color       <= c;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sb.note_item(f, idx, c);
    items_sent++;
  endtask

  // Hold input idle until every result is back and the pipeline is empty
  task automatic settle();
    req_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic load_timing(input logic [CFG_DW-1:0] oh, input logic [CFG_DW-1:0] ol,
                             input logic [CFG_DW-1:0] zh, input logic [CFG_DW-1:0] zl,
                             input logic [CFG_DW-1:0] pc, input bit poke_unused);
    settle();
    reg_write(CFG_ONE_HIGH, oh);
    reg_write(CFG_ONE_LOW, ol);
    reg_write(CFG_ZERO_HIGH, zh);
    reg_write(CFG_ZERO_LOW, zl);
    reg_write(CFG_PIX_COUNT, pc);
    if (poke_unused) reg_write(CFG_UNUSED, CFG_DW'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Busy-time noise: stores and starts here must be dropped by the block
  task automatic send_noise();
    func_t f;
    case ($urandom_range(0, 2))
      0:       f = FUNC_STORE;
      1:       f = FUNC_START;
      default: f = FUNC_UNUSED;
    endcase
    send_item(f, PIX_AW'($urandom), rand_color());
  endtask

  task automatic run_frame(input int noise_pct);
    send_item(FUNC_START, PIX_AW'($urandom), rand_color());
    while (sb.sending) begin
      if ($urandom_range(99) < noise_pct) begin
        send_noise();
      end else begin
        send_item(FUNC_TICK, PIX_AW'($urandom), rand_color());
      end
    end
  endtask

  initial begin
    int                 target;
    int                 sel;
    int                 max_dur;
    logic [CFG_DW-1:0]  pc;

    sb.reset_state();
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    req_if.valid       = 1'b0;
    req_if.func        = FUNC_TICK;
    req_if.pixel_index = '0;
    req_if.color       = '0;
    rsp_if.ready       = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Idle traffic: a tick and the unused code leave the line low; stores fill slots 15 and 0
    send_item(FUNC_TICK, '0, '0);
    send_item(FUNC_UNUSED, '1, '1);
    send_item(FUNC_STORE, PIX_AW'(15), 24'hFFFFFF);
    send_item(FUNC_STORE, '0, 24'h800000);

    // Long one-bit phases, zero-length zero-bit phases, one pixel
    load_timing(12'd40, 12'd30, 12'd0, 12'd0, 12'd1, 1'b1);
    send_item(FUNC_START, '0, '0);
    send_item(FUNC_TICK, '0, '0);
    send_item(FUNC_STORE, '0, 24'h000000);
    send_item(FUNC_START, '1, '1);
    while (sb.sending) send_item(FUNC_TICK, '1, '1);
    send_item(FUNC_TICK, '0, '0);

    // Long zero-bit phases, shortest one-bit phases, pixel count of zero
    send_item(FUNC_STORE, '0, 24'hFFFFFE);
    load_timing(12'd1, 12'd0, 12'd40, 12'd30, 12'd0, 1'b0);
    run_frame(0);

    // Pixel count above the store size sends all sixteen pixels, no idling
    send_item(FUNC_STORE, '0, 24'h000000);
    send_item(FUNC_STORE, PIX_AW'(1), 24'hFFFFFF);
    send_item(FUNC_STORE, PIX_AW'(2), 24'hAAAAAA);
    send_item(FUNC_STORE, PIX_AW'(3), 24'h555555);
    for (int i = 4; i < PIX_DEPTH; i++) send_item(FUNC_STORE, PIX_AW'(i), rand_color());
    load_timing(12'd0, 12'd1, 12'd2, 12'd1, 12'd31, 1'b0);
    no_gaps = 1'b1;
    run_frame(0);
    no_gaps = 1'b0;

    // Random frames: mostly well-formed, with noise while busy and idle
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      if ($urandom_range(99) < 70) begin
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
          pc = 12'd1;
        end else if (sel < 80) begin
          pc = CFG_DW'($urandom_range(2, 3));
        end else if (sel < 88) begin
          pc = 12'd0;
        end else if (sel < 94) begin
          pc = {7'($urandom_range(1, 127)), 5'd1};
        end else begin
          pc = CFG_DW'($urandom_range(4, 31));
        end
        max_dur = (pc[PCNT_W-1:0] > 5'd3) ? 1 : 3;
        load_timing(CFG_DW'($urandom_range(0, max_dur)), CFG_DW'($urandom_range(0, max_dur)),
                    CFG_DW'($urandom_range(0, max_dur)), CFG_DW'($urandom_range(0, max_dur)),
                    pc, $urandom_range(0, 9) == 0);
      end
      repeat ($urandom_range(0, 4)) send_item(FUNC_STORE, PIX_AW'($urandom), rand_color());
      repeat ($urandom_range(0, 2)) begin
        send_item(($urandom_range(0, 1) == 0) ? FUNC_TICK : FUNC_UNUSED,
                  PIX_AW'($urandom), rand_color());
      end
      if ($urandom_range(99) < 90) run_frame(6);
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("ws2812_led_serializer_tb: done, clean");
    end else begin
      $display("ws2812_led_serializer_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> ws2812_led_serializer.f
hw/rtl/wls_pkg.sv
hw/rtl/wls_in_if.sv
hw/rtl/wls_out_if.sv
hw/rtl/wls_pixel_store.sv
hw/rtl/wls_engine.sv
hw/rtl/ws2812_led_serializer.sv
sim/ws2812_led_serializer_tb.sv
